@@ rtl/assert_macros.svh @@
// assertion macros used by the rasterizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent holding implies consequent on the following edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent holding implies consequent on the same edge
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/dda_lr_pkg.sv @@
// package with types and constants for the dda line rasterizer
`default_nettype none

package dda_lr_pkg;

    localparam int COORD_W       = 6;
    localparam int COLOR_W       = 24;
    localparam int TILE_SIZE_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int S_DATA_W      = 48;
    localparam int M_DATA_W      = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } lr_state_t;

    // request to the slope divider
    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] mag;
        logic [COORD_W-1:0] den;
    } div_req_t;

endpackage

`default_nettype wire

@@ rtl/dda_line_rasterizer_unit.sv @@
// top level of the dda line rasterizer
//
//  channel | dir | word contents
//  s_*     | in  | one line segment: endpoints and color
//  m_*     | out | one pixel write, tlast on the final pixel of a line
//
// a line gives n pixel writes, n = pixels drawn (1..63)
// the slope comes from one shift-subtract divider, one quotient bit per cycle
// an empty run (x_end = x_start, y_end <= y_start) is accepted from idle with no output
// rst_n clears the sequencer and the divider control; no segment is held
// a stall on m_tready holds the pixel and the stepping
`default_nettype none

module dda_line_rasterizer_unit
    import dda_lr_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // x_start, y_start, x_end, y_end, color
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // pixel_x, pixel_y, pixel_color, zero pad
    output logic                     m_tlast
);

    `include "assert_macros.svh"

    localparam int QW    = COORD_W + FRAC_BITS;
    localparam int SW    = QW + 1;
    localparam int ACC_W = FRAC_BITS + 9;
    localparam int INT_W = ACC_W - 1 - FRAC_BITS;
    localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

    lr_state_t state_reg, state_next;

    logic [COORD_W-1:0] xs, ys, xe, ye;
    logic [COLOR_W-1:0] col_in;
    logic signed [COORD_W:0] dx, dy, num, den_s;
    logic [COORD_W:0]   num_abs;
    logic               case_left, case_right, step_x, empty_run, accept, emit;

    logic [COORD_W-1:0] pos_reg, pos_next;
    logic [COORD_W-1:0] end_reg, end_next;
    logic               down_reg, down_next;
    logic               stepx_reg, stepx_next;
    logic               neg_reg, neg_next;
    logic [COLOR_W-1:0] col_reg, col_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SW-1:0]      slope_reg, slope_next;

    div_req_t           div_req;
    logic               div_done;
    logic [QW-1:0]      div_quot;

    logic               last_pix;
    logic [COORD_W-1:0] pos_pix, acc_pix;
    logic [INT_W-1:0]   acc_int;

    assign xs     = s_tdata[5:0];
    assign ys     = s_tdata[11:6];
    assign xe     = s_tdata[17:12];
    assign ye     = s_tdata[23:18];
    assign col_in = s_tdata[47:24];

    assign dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
    assign dy = $signed({1'b0, ye}) - $signed({1'b0, ys});

    assign case_left  = dx[COORD_W] && ((-dx) > dy);
    assign case_right = !dx[COORD_W] && (dx > dy);
    assign step_x     = case_left || case_right;
    assign num        = step_x ? dy : dx;
    assign den_s      = step_x ? (dx[COORD_W] ? -dx : dx) : dy;
    assign num_abs    = num[COORD_W] ? (COORD_W+1)'(0) - num : num;
    assign empty_run  = (xs == xe) && (ye <= ys);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !empty_run)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_tready && last_pix)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        div_req.start = 1'b0;
        div_req.mag   = num_abs[COORD_W-1:0];
        div_req.den   = den_s[COORD_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                div_req.start = s_tvalid && !empty_run;
            end
            ST_DIV:  ;
            ST_EMIT: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign emit   = m_tvalid && m_tready;

    assign last_pix = down_reg ? ({1'b0, pos_reg} - 7'd1 == {1'b0, end_reg})
                               : ({1'b0, pos_reg} + 7'd1 == {1'b0, end_reg});

    always_comb
    begin
        pos_next   = pos_reg;
        end_next   = end_reg;
        down_next  = down_reg;
        stepx_next = stepx_reg;
        neg_next   = neg_reg;
        col_next   = col_reg;
        acc_next   = acc_reg;
        slope_next = slope_reg;
        if (accept)
        begin
            pos_next   = step_x ? xs : ys;
            end_next   = step_x ? xe : ye;
            down_next  = case_left;
            stepx_next = step_x;
            neg_next   = num[COORD_W];
            col_next   = col_in;
            acc_next   = {3'b000, (step_x ? ys : xs), {FRAC_BITS{1'b0}}};
        end
        if (div_done)
            slope_next = neg_reg ? SW'(0) - {1'b0, div_quot} : {1'b0, div_quot};
        if (emit)
        begin
            pos_next = down_reg ? pos_reg - COORD_W'(1) : pos_reg + COORD_W'(1);
            acc_next = acc_reg + {{(ACC_W-SW){slope_reg[SW-1]}}, slope_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        end_reg   <= end_next;
        down_reg  <= down_next;
        stepx_reg <= stepx_next;
        neg_reg   <= neg_next;
        col_reg   <= col_next;
        acc_reg   <= acc_next;
        slope_reg <= slope_next;
    end

    dda_lr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // clamp both coordinates to the tile
    assign acc_int = acc_reg[ACC_W-2:FRAC_BITS];
    assign pos_pix = (pos_reg > TILE_MAX) ? TILE_MAX : pos_reg;
    assign acc_pix = acc_reg[ACC_W-1]                          ? '0 :
                     (acc_int > {{(INT_W-COORD_W){1'b0}}, TILE_MAX}) ? TILE_MAX :
                     acc_int[COORD_W-1:0];

    assign m_tdata = {4'b0000, col_reg,
                      (stepx_reg ? acc_pix : pos_pix),
                      (stepx_reg ? pos_pix : acc_pix)};
    assign m_tlast = last_pix;

    `ASSERT_ALWAYS(a_one_side, !(s_tready && m_tvalid), "input and output open together")
    `ASSERT_SAME(a_done_in_div, div_done, state_reg == ST_DIV, "divider done outside division")
    `ASSERT_NEXT(a_last_ends, emit && m_tlast, s_tready, "line did not end after last pixel")
    `ASSERT_NEXT(a_run_goes_on, emit && !m_tlast, m_tvalid, "line stopped before last pixel")

endmodule

`default_nettype wire

@@ rtl/dda_lr_div.sv @@
// iterative restoring divider for the slope magnitude
`default_nettype none

module dda_lr_div
    import dda_lr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire div_req_t                     req,
    output logic                              done,
    output logic [COORD_W+FRAC_BITS-1:0]      quot
);

    localparam int QW    = COORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W-1:0] den_reg, den_next;
    logic [QW-1:0]      dvd_reg, dvd_next;
    logic [COORD_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = '0;
            den_next  = req.den;
            dvd_next  = {req.mag, {FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next = fits ? COORD_W'(trial - {1'b0, den_reg}) : trial[COORD_W-1:0];
            dvd_next = {dvd_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dvd_reg <= dvd_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

`default_nettype wire
